// ----- src/ddsup_pkg.sv -----
// Shared types and constants for the distance duplicate suppression block.
// Used by the register file, distance pipeline and top level; no dependencies.
`default_nettype none
package ddsup_pkg;

    localparam int MAX_FUSED = 64;
    localparam int IDX_W     = $clog2(MAX_FUSED);
    localparam int CNT_W     = $clog2(MAX_FUSED + 1);

    localparam int POS_W     = 20;
    localparam int ENTRY_W   = 3 * POS_W;
    localparam int DIFF_W    = POS_W + 1;
    localparam int SQ_W      = 2 * POS_W + 1;
    localparam int SUM_W     = SQ_W + 2;
    localparam int THR_W     = 16;
    localparam int THR2_W    = 2 * THR_W;
    localparam int ID_W      = 32;
    localparam int INC_W     = 8;

    localparam int DUP_W     = 6;
    localparam int SCNT_W    = 7;

    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(500);
    localparam logic [INC_W-1:0] INC_RESET = INC_W'(1);

    typedef enum logic [1:0] {
        REG_THR    = 2'd0,
        REG_OFFSET = 2'd1,
        REG_INC    = 2'd2,
        REG_NONE   = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_DET = 2'd0,
        MODE_END = 2'd1,
        MODE_NEW = 2'd2,
        MODE_RSV = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_KEPT = 2'd0,
        STAT_DUP  = 2'd1,
        STAT_FULL = 2'd2,
        STAT_CTRL = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [THR_W-1:0] thr;
        logic [ID_W-1:0]  offset;
        logic [INC_W-1:0] inc;
        logic             load_id;
    } t_cfg;

    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [IDX_W-1:0] idx;
        logic             busy;
    } t_dist_res;

endpackage
`default_nettype wire

// ----- src/distance_duplicate_suppression.sv -----
// Distance duplicate suppression: each detection is compared, one stored entry per
// cycle, against the positions committed by earlier sensor batches of the frame;
// the first entry within the squared threshold marks it a duplicate, otherwise it
// is appended and gets the next id unless the store is full. The committed
// count (at most 64) bounds the scan, which runs through the single read port
// of the position memory and the three-stage distance pipeline; a match stops
// the scan, and the result follows once the reads already issued drain. Control
// items skip the scan. One item is in work at a time; a finished result waits
// in the output register while the next item is accepted.
// Depends on ddsup_pkg, ddsup_ram, ddsup_regs, ddsup_dist.
`default_nettype none
module distance_duplicate_suppression (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [63:0]                   s_axis_tdata, // pos_x, pos_y, pos_z
    input  wire logic [1:0]                    s_axis_tuser, // mode
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [47:0]                   m_axis_tdata, // duplicate_of, assigned_id,
                                                             // stored_count
    output logic      [1:0]                    m_axis_tuser, // status
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ddsup_pkg::PADDR_W-1:0] paddr,
    input  wire logic [ddsup_pkg::PDATA_W-1:0] pwdata,
    output logic      [ddsup_pkg::PDATA_W-1:0] prdata,
    output logic                               pready
);

    localparam int IW = ddsup_pkg::IDX_W;
    localparam int CW = ddsup_pkg::CNT_W;
    localparam int EW = ddsup_pkg::ENTRY_W;
    localparam logic [CW-1:0] CNT_MAX = CW'(ddsup_pkg::MAX_FUSED);

    ddsup_pkg::t_cfg      cfg;
    ddsup_pkg::t_dist_res dres;

    ddsup_pkg::t_state    r_state, n_state;
    ddsup_pkg::t_mode     r_mode;
    logic [EW-1:0]        r_pos;
    logic [CW-1:0]        r_fused_cnt, r_comm_cnt, r_issue_cnt;
    logic [ddsup_pkg::ID_W-1:0] r_next_id;
    logic                 r_rd_v;
    logic [IW-1:0]        r_rd_idx;
    logic                 r_found;
    logic [IW-1:0]        r_dup_idx;
    logic                 r_m_valid;
    logic [1:0]           r_m_user;
    logic [47:0]          r_m_data;
    logic [EW-1:0]        rd_data;

    logic                 accept, issue, scan_done, push, keep;
    ddsup_pkg::t_status   status;
    logic [CW-1:0]        n_fused_cnt;
    logic [ddsup_pkg::DUP_W-1:0] res_dup;
    logic [ddsup_pkg::ID_W-1:0]  res_id;

    ddsup_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ddsup_ram #(
        .WIDTH (EW),
        .DEPTH (ddsup_pkg::MAX_FUSED)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (keep),
        .i_waddr (r_fused_cnt[IW-1:0]),
        .i_wdata (r_pos),
        .i_re    (issue),
        .i_raddr (r_issue_cnt[IW-1:0]),
        .o_rdata (rd_data)
    );

    ddsup_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_v),
        .i_idx   (r_rd_idx),
        .i_entry (rd_data),
        .i_query (r_pos),
        .i_thr   (cfg.thr),
        .o_res   (dres)
    );

    assign s_axis_tready = (r_state == ddsup_pkg::S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign issue         = (r_state == ddsup_pkg::S_SCAN) && !r_found
                           && (r_issue_cnt < r_comm_cnt);
    assign scan_done     = (r_found || (r_issue_cnt == r_comm_cnt)) && !r_rd_v && !dres.busy;
    assign push          = (r_state == ddsup_pkg::S_FIN) && (!r_m_valid || m_axis_tready);

    always_comb begin
        status = ddsup_pkg::STAT_CTRL;
        if (r_mode == ddsup_pkg::MODE_DET) begin
            if (r_found) begin
                status = ddsup_pkg::STAT_DUP;
            end else if (r_fused_cnt >= CNT_MAX) begin
                status = ddsup_pkg::STAT_FULL;
            end else begin
                status = ddsup_pkg::STAT_KEPT;
            end
        end
        keep        = push && (status == ddsup_pkg::STAT_KEPT);
        n_fused_cnt = r_fused_cnt;
        if (status == ddsup_pkg::STAT_KEPT) begin
            n_fused_cnt = r_fused_cnt + CW'(1);
        end else if (r_mode == ddsup_pkg::MODE_NEW) begin
            n_fused_cnt = '0;
        end
        res_dup = (status == ddsup_pkg::STAT_DUP) ? ddsup_pkg::DUP_W'(r_dup_idx) : '0;
        res_id  = (status == ddsup_pkg::STAT_KEPT) ? r_next_id : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddsup_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ddsup_pkg::S_IDLE: begin
                if (accept) begin
                    if (ddsup_pkg::t_mode'(s_axis_tuser) == ddsup_pkg::MODE_DET) begin
                        n_state = ddsup_pkg::S_SCAN;
                    end else begin
                        n_state = ddsup_pkg::S_FIN;
                    end
                end
            end
            ddsup_pkg::S_SCAN: begin
                if (scan_done) begin
                    n_state = ddsup_pkg::S_FIN;
                end
            end
            ddsup_pkg::S_FIN: begin
                if (push) begin
                    n_state = ddsup_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ddsup_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fused_cnt <= '0;
            r_comm_cnt  <= '0;
            r_issue_cnt <= '0;
            r_next_id   <= '0;
            r_rd_v      <= 1'b0;
            r_found     <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_rd_v <= issue;
            if (accept) begin
                r_issue_cnt <= '0;
                r_found     <= 1'b0;
            end else if (issue) begin
                r_issue_cnt <= r_issue_cnt + CW'(1);
            end
            if (dres.valid && dres.hit && !r_found) begin
                r_found <= 1'b1;
            end
            if (cfg.load_id) begin
                r_next_id <= cfg.offset;
            end else if (keep) begin
                r_next_id <= r_next_id + ddsup_pkg::ID_W'(cfg.inc);
            end
            if (push) begin
                r_fused_cnt <= n_fused_cnt;
                if (r_mode == ddsup_pkg::MODE_END) begin
                    r_comm_cnt <= r_fused_cnt;
                end else if (r_mode == ddsup_pkg::MODE_NEW) begin
                    r_comm_cnt <= '0;
                end
            end
            if (push) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= ddsup_pkg::t_mode'(s_axis_tuser);
            r_pos  <= s_axis_tdata[EW-1:0];
        end
        r_rd_idx <= r_issue_cnt[IW-1:0];
        if (dres.valid && dres.hit && !r_found) begin
            r_dup_idx <= dres.idx;
        end
        if (push) begin
            r_m_user <= status;
            r_m_data <= {3'b000, ddsup_pkg::SCNT_W'(n_fused_cnt), res_id, res_dup};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_comm_cnt <= r_fused_cnt) && (r_fused_cnt <= CNT_MAX))
        else $error("committed count exceeds fused count or store size");

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue_cnt <= r_comm_cnt)
        else $error("scan read beyond committed entries");

    a_dup_committed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (CW'(r_dup_idx) < r_comm_cnt))
        else $error("duplicate index outside committed entries");

    a_keep_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        keep |=> (r_fused_cnt == $past(r_fused_cnt) + CW'(1)))
        else $error("kept detection did not advance fused count");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (!r_m_valid || m_axis_tready))
        else $error("result pushed over a pending output");

endmodule
`default_nettype wire

// ----- src/ddsup_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module ddsup_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- src/ddsup_regs.sv -----
// APB configuration registers: threshold, id offset and id increment.
// Depends on ddsup_pkg.
`default_nettype none
module ddsup_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ddsup_pkg::PADDR_W-1:0] paddr,
    input  wire logic [ddsup_pkg::PDATA_W-1:0] pwdata,
    output logic      [ddsup_pkg::PDATA_W-1:0] prdata,
    output logic                               pready,
    output ddsup_pkg::t_cfg                    o_cfg
);

    logic [ddsup_pkg::THR_W-1:0] r_thr;
    logic [ddsup_pkg::ID_W-1:0]  r_offset;
    logic [ddsup_pkg::INC_W-1:0] r_inc;
    logic                        r_load;
    logic                        wr_en;
    ddsup_pkg::t_reg_idx         idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = ddsup_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= ddsup_pkg::THR_RESET;
            r_offset <= '0;
            r_inc    <= ddsup_pkg::INC_RESET;
            r_load   <= 1'b0;
        end else begin
            r_load <= 1'b0;
            if (wr_en) begin
                unique case (idx)
                    ddsup_pkg::REG_THR: begin
                        r_thr <= pwdata[ddsup_pkg::THR_W-1:0];
                    end
                    ddsup_pkg::REG_OFFSET: begin
                        r_offset <= pwdata[ddsup_pkg::ID_W-1:0];
                        r_load   <= 1'b1;
                    end
                    ddsup_pkg::REG_INC: begin
                        r_inc <= pwdata[ddsup_pkg::INC_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        unique case (idx)
            ddsup_pkg::REG_THR:    prdata = ddsup_pkg::PDATA_W'(r_thr);
            ddsup_pkg::REG_OFFSET: prdata = ddsup_pkg::PDATA_W'(r_offset);
            ddsup_pkg::REG_INC:    prdata = ddsup_pkg::PDATA_W'(r_inc);
            default:               prdata = '0;
        endcase
    end

    assign o_cfg.thr     = r_thr;
    assign o_cfg.offset  = r_offset;
    assign o_cfg.inc     = r_inc;
    assign o_cfg.load_id = r_load;

endmodule
`default_nettype wire

// ----- src/ddsup_dist.sv -----
// Three-stage squared-distance pipeline: difference, square, sum and compare.
// Depends on ddsup_pkg.
`default_nettype none
module ddsup_dist (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire logic [ddsup_pkg::IDX_W-1:0]      i_idx,
    input  wire logic [ddsup_pkg::ENTRY_W-1:0]    i_entry,
    input  wire logic [ddsup_pkg::ENTRY_W-1:0]    i_query,
    input  wire logic [ddsup_pkg::THR_W-1:0]      i_thr,
    output ddsup_pkg::t_dist_res                  o_res
);

    localparam int PW = ddsup_pkg::POS_W;
    localparam int DW = ddsup_pkg::DIFF_W;
    localparam int QW = ddsup_pkg::SQ_W;
    localparam int SW = ddsup_pkg::SUM_W;

    logic                          r_v1, r_v2, r_v3;
    logic [ddsup_pkg::IDX_W-1:0]   r_i1, r_i2, r_i3;
    logic signed [DW-1:0]          r_dx, r_dy, r_dz;
    logic [QW-1:0]                 r_sx, r_sy, r_sz;
    logic [ddsup_pkg::THR2_W-1:0]  r_thr2;
    logic                          r_hit;

    logic signed [DW-1:0]          dx, dy, dz;
    logic signed [2*DW-1:0]        px, py, pz;
    logic [SW-1:0]                 sum;

    always_comb begin
        dx = $signed({i_query[PW-1], i_query[PW-1:0]})
           - $signed({i_entry[PW-1], i_entry[PW-1:0]});
        dy = $signed({i_query[2*PW-1], i_query[2*PW-1:PW]})
           - $signed({i_entry[2*PW-1], i_entry[2*PW-1:PW]});
        dz = $signed({i_query[3*PW-1], i_query[3*PW-1:2*PW]})
           - $signed({i_entry[3*PW-1], i_entry[3*PW-1:2*PW]});
        px = r_dx * r_dx;
        py = r_dy * r_dy;
        pz = r_dz * r_dz;
        sum = SW'(r_sx) + SW'(r_sy) + SW'(r_sz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr2 <= ddsup_pkg::THR2_W'(i_thr) * ddsup_pkg::THR2_W'(i_thr);
        r_i1   <= i_idx;
        r_dx   <= dx;
        r_dy   <= dy;
        r_dz   <= dz;
        r_i2   <= r_i1;
        r_sx   <= px[QW-1:0];
        r_sy   <= py[QW-1:0];
        r_sz   <= pz[QW-1:0];
        r_i3   <= r_i2;
        r_hit  <= sum < SW'(r_thr2);
    end

    assign o_res.valid = r_v3;
    assign o_res.hit   = r_hit;
    assign o_res.idx   = r_i3;
    assign o_res.busy  = r_v1 || r_v2 || r_v3;

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for distance_duplicate_suppression: directed and random
// detection streams with its own duplicate-suppression predictor and APB setup.
// Depends on ddsup_pkg and the RTL of the block only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT = 3000;
    localparam int unsigned REPORT_MAX  = 10;

    typedef struct packed {
        ddsup_pkg::t_status status;
        logic [5:0]         dup;
        logic [31:0]        id;
        logic [6:0]         cnt;
    } t_verdict;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata = '0;   // pos_x, pos_y, pos_z
    logic [1:0]           s_axis_tuser = '0;   // mode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [47:0]          m_axis_tdata;        // duplicate_of, assigned_id, stored_count
    logic [1:0]           m_axis_tuser;        // status
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ddsup_pkg::PADDR_W-1:0] paddr = '0;
    logic [ddsup_pkg::PDATA_W-1:0] pwdata = '0;
    logic [ddsup_pkg::PDATA_W-1:0] prdata;
    logic                 pready;

    // predictor state
    logic signed [19:0]   fused_x [ddsup_pkg::MAX_FUSED];
    logic signed [19:0]   fused_y [ddsup_pkg::MAX_FUSED];
    logic signed [19:0]   fused_z [ddsup_pkg::MAX_FUSED];
    int unsigned          fill_n = 0;
    int unsigned          committed_n = 0;
    logic [31:0]          id_ctr = '0;
    logic [15:0]          thr_cfg = 16'd500;
    logic [7:0]           inc_cfg = 8'd1;

    t_verdict             pending_verdicts [$];
    int unsigned          mismatch_count = 0;
    int unsigned          stall_cycles = 0;
    bit                   steady = 1'b0;

    distance_duplicate_suppression dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_verdict suppress_predict(ddsup_pkg::t_mode mode,
                                                  logic signed [19:0] x,
                                                  logic signed [19:0] y,
                                                  logic signed [19:0] z);
        t_verdict v;
        longint   lim2, dx, dy, dz;
        bit       hit;
        v.status = ddsup_pkg::STAT_CTRL;
        v.dup = '0;
        v.id = '0;
        hit = 1'b0;
        case (mode)
            ddsup_pkg::MODE_DET: begin
                lim2 = longint'(thr_cfg) * longint'(thr_cfg);
                for (int i = 0; i < committed_n && !hit; i++) begin
                    dx = longint'(x) - longint'(fused_x[i]);
                    dy = longint'(y) - longint'(fused_y[i]);
                    dz = longint'(z) - longint'(fused_z[i]);
                    if (dx * dx + dy * dy + dz * dz < lim2) begin
                        hit = 1'b1;
                        v.dup = 6'(i);
                    end
                end
                if (hit) begin
                    v.status = ddsup_pkg::STAT_DUP;
                end else if (fill_n >= ddsup_pkg::MAX_FUSED) begin
                    v.status = ddsup_pkg::STAT_FULL;
                end else begin
                    fused_x[fill_n] = x;
                    fused_y[fill_n] = y;
                    fused_z[fill_n] = z;
                    fill_n++;
                    v.status = ddsup_pkg::STAT_KEPT;
                    v.id = id_ctr;
                    id_ctr = id_ctr + 32'(inc_cfg);
                end
            end
            ddsup_pkg::MODE_END: committed_n = fill_n;
            ddsup_pkg::MODE_NEW: begin
                fill_n = 0;
                committed_n = 0;
            end
            default: ;
        endcase
        v.cnt = 7'(fill_n);
        return v;
    endfunction

    function automatic logic signed [19:0] rand_pos();
        return 20'($urandom);
    endfunction

    function automatic logic signed [19:0] near(logic signed [19:0] c, int unsigned spread);
        int off;
        off = int'($urandom_range(2 * spread)) - int'(spread);
        return c + 20'(off);
    endfunction

    task automatic send_item(ddsup_pkg::t_mode mode, logic signed [19:0] x,
                             logic signed [19:0] y, logic signed [19:0] z);
        while (!steady && $urandom_range(99) < 18) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {4'b0, z, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_verdicts.insert(pending_verdicts.size(), suppress_predict(mode, x, y, z));
    endtask

    task automatic send_random_ctrl(ddsup_pkg::t_mode mode);
        send_item(mode, rand_pos(), rand_pos(), rand_pos());
    endtask

    // hold off the stream until every transaction has come back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(ddsup_pkg::t_reg_idx idx, logic [31:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ddsup_pkg::REG_THR:    thr_cfg = value[15:0];
            ddsup_pkg::REG_OFFSET: id_ctr = value;
            ddsup_pkg::REG_INC:    inc_cfg = value[7:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [15:0] thr, logic [31:0] offset, logic [7:0] inc);
        write_reg(ddsup_pkg::REG_THR, 32'(thr));
        write_reg(ddsup_pkg::REG_OFFSET, offset);
        write_reg(ddsup_pkg::REG_INC, 32'(inc));
    endtask

    task automatic test_directed();
        send_random_ctrl(ddsup_pkg::MODE_RSV);
        send_item(ddsup_pkg::MODE_DET, -20'sd524288, -20'sd524288, -20'sd524288);
        send_item(ddsup_pkg::MODE_DET, 20'sd524287, 20'sd524287, 20'sd524287);
        // same batch: no comparison against the first entry
        send_item(ddsup_pkg::MODE_DET, -20'sd524288, -20'sd524288, -20'sd524288);
        send_random_ctrl(ddsup_pkg::MODE_END);
        send_item(ddsup_pkg::MODE_DET, -20'sd524000, -20'sd524000, -20'sd524000);
        // exactly at the threshold is not a duplicate
        send_item(ddsup_pkg::MODE_DET, 20'sd523787, 20'sd524287, 20'sd524287);
        send_item(ddsup_pkg::MODE_DET, 20'sd523788, 20'sd524287, 20'sd524287);
        send_item(ddsup_pkg::MODE_DET, 20'sd0, 20'sd0, 20'sd0);
        send_random_ctrl(ddsup_pkg::MODE_NEW);
        send_random_ctrl(ddsup_pkg::MODE_RSV);
    endtask

    task automatic test_config_extremes();
        configure(16'd0, 32'hFFFF_FFFF, 8'd255);
        send_item(ddsup_pkg::MODE_DET, 20'sd100, -20'sd100, 20'sd7);
        send_random_ctrl(ddsup_pkg::MODE_END);
        send_item(ddsup_pkg::MODE_DET, 20'sd100, -20'sd100, 20'sd7);
        write_reg(ddsup_pkg::REG_INC, 32'd0);
        send_item(ddsup_pkg::MODE_DET, 20'sd5, 20'sd5, 20'sd5);
        send_item(ddsup_pkg::MODE_DET, 20'sd6, 20'sd6, 20'sd6);
        configure(16'hFFFF, 32'h8000_0000, 8'd1);
        send_random_ctrl(ddsup_pkg::MODE_END);
        send_item(ddsup_pkg::MODE_DET, 20'sd65534, 20'sd100, 20'sd7);
        send_item(ddsup_pkg::MODE_DET, 20'sd65535, -20'sd100, 20'sd7);
        send_item(ddsup_pkg::MODE_DET, -20'sd524288, 20'sd524287, -20'sd524288);
        send_random_ctrl(ddsup_pkg::MODE_NEW);
    endtask

    task automatic run_frames(int unsigned n_items, int unsigned max_batch);
        logic signed [19:0] cx [8];
        logic signed [19:0] cy [8];
        logic signed [19:0] cz [8];
        int unsigned        sent, spread, pick, roll;
        sent = 0;
        while (sent < n_items) begin
            for (int c = 0; c < 8; c++) begin
                cx[c] = rand_pos();
                cy[c] = rand_pos();
                cz[c] = rand_pos();
            end
            spread = (thr_cfg == 0) ? 64 : thr_cfg;
            send_random_ctrl(ddsup_pkg::MODE_NEW);
            sent++;
            repeat ($urandom_range(1, 5)) begin
                repeat ($urandom_range(max_batch)) begin
                    roll = $urandom_range(99);
                    pick = $urandom_range(7);
                    if (roll < 3) begin
                        send_random_ctrl(ddsup_pkg::MODE_RSV);
                    end else if (roll < 5) begin
                        send_random_ctrl(ddsup_pkg::t_mode'($urandom_range(1, 2)));
                        sent++;
                    end else if (roll < 22) begin
                        send_item(ddsup_pkg::MODE_DET, rand_pos(), rand_pos(), rand_pos());
                        sent++;
                    end else begin
                        send_item(ddsup_pkg::MODE_DET, near(cx[pick], spread),
                                  near(cy[pick], spread), near(cz[pick], spread));
                        sent++;
                    end
                end
                send_random_ctrl(ddsup_pkg::MODE_END);
                sent++;
            end
        end
    endtask

    task automatic fill_store();
        int unsigned pick;
        send_random_ctrl(ddsup_pkg::MODE_NEW);
        repeat ($urandom_range(ddsup_pkg::MAX_FUSED, ddsup_pkg::MAX_FUSED + 4))
            send_item(ddsup_pkg::MODE_DET, rand_pos(), rand_pos(), rand_pos());
        send_random_ctrl(ddsup_pkg::MODE_END);
        repeat (30) begin
            pick = ($urandom_range(3) == 0) ? ddsup_pkg::MAX_FUSED - 1
                                            : $urandom_range(ddsup_pkg::MAX_FUSED - 1);
            if ($urandom_range(1))
                send_item(ddsup_pkg::MODE_DET, near(fused_x[pick], 4), near(fused_y[pick], 4),
                          near(fused_z[pick], 4));
            else
                send_item(ddsup_pkg::MODE_DET, rand_pos(), rand_pos(), rand_pos());
        end
    endtask

    task automatic test_random();
        steady = 1'b1;
        configure(16'd500, $urandom, 8'd1);
        run_frames(350, 12);
        steady = 1'b0;
        configure(16'($urandom_range(1, 3000)), 32'hFFFF_FF80, 8'd255);
        run_frames(350, 12);
        configure(16'hFFFF, $urandom, 8'($urandom_range(1, 255)));
        run_frames(200, 12);
        fill_store();
        configure(16'd0, $urandom, 8'($urandom_range(1, 255)));
        run_frames(200, 30);
        configure(16'($urandom_range(1, 20000)), $urandom, 8'($urandom_range(1, 255)));
        fill_store();
        run_frames(250, 20);
    endtask

    always @(posedge i_clk) begin
        t_verdict got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = ddsup_pkg::t_status'(m_axis_tuser);
            got.dup    = m_axis_tdata[5:0];
            got.id     = m_axis_tdata[37:6];
            got.cnt    = m_axis_tdata[44:38];
            if (pending_verdicts.size() == 0) begin
                if (mismatch_count < REPORT_MAX)
                    $display("%0t: unexpected result status=%0d dup=%0d id=%h count=%0d",
                             $realtime, got.status, got.dup, got.id, got.cnt);
                mismatch_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (got.status !== want.status || got.dup !== want.dup ||
                    got.id !== want.id || got.cnt !== want.cnt) begin
                    if (mismatch_count < REPORT_MAX)
                        $display("%0t: mismatch status %0d/%0d dup %0d/%0d id %h/%h count %0d/%0d",
                                 $realtime, want.status, got.status, want.dup, got.dup,
                                 want.id, got.id, want.cnt, got.cnt);
                    mismatch_count++;
                end
            end
        end
        m_axis_tready <= steady || ($urandom_range(99) >= 18);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        test_random();
        settle();
        repeat (80) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
